// ----- src/isotp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the CAN transport protocol frame reassembler.
package isotp_pkg;

    // Protocol control information: frame type in the high nibble of byte zero.
    localparam logic [3:0] FT_SINGLE      = 4'h0;
    localparam logic [3:0] FT_FIRST       = 4'h1;
    localparam logic [3:0] FT_CONSECUTIVE = 4'h2;
    localparam logic [3:0] FT_FLOW        = 4'h3;

    // Frame geometry limits.
    localparam logic [3:0]  SF_MAX_LEN      = 4'd7;
    localparam logic [11:0] FF_MIN_LEN      = 12'd8;
    localparam logic [2:0]  FF_PAYLOAD_CNT  = 3'd6;
    localparam logic [11:0] FF_NEXT_OFFSET  = 12'd6;
    localparam logic [11:0] CF_MAX_CNT      = 12'd7;
    localparam logic [3:0]  CF_FIRST_SEQ    = 4'd1;
    localparam logic [7:0]  FC_CTS_BYTE     = 8'h30;

    // Configuration register reset values and byte address decode.
    localparam logic [7:0] ST_RESET   = 8'd5;
    localparam logic [7:0] BS_RESET   = 8'd0;
    localparam int         ADDR_WIDTH = 3;
    localparam logic       REG_STMIN  = 1'b0;
    localparam logic       REG_BS     = 1'b1;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_IGNORED     = 3'd0,
        EV_SINGLE_DONE = 3'd1,
        EV_FIRST_OK    = 3'd2,
        EV_CONSEC_OK   = 3'd3,
        EV_MSG_DONE    = 3'd4,
        EV_SEQ_ERROR   = 3'd5,
        EV_FLOW        = 3'd6
    } event_kind_t;

    // Flow control settings handed from the register file to the core.
    typedef struct packed {
        logic [7:0] block_size;
        logic [7:0] separation_time;
    } fc_cfg_t;

    // One result beat.
    typedef struct packed {
        event_kind_t  event_kind;
        logic [55:0]  payload_bytes;
        logic [2:0]   payload_count;
        logic [11:0]  write_offset;
        logic [11:0]  message_length;
        logic         send_flow_control;
        logic [23:0]  fc_frame_bytes;
        logic [3:0]   flow_status;
    } result_t;

endpackage

// ----- src/isotp_cfg_regs.sv -----
`timescale 1ns / 1ps
// APB register file holding the flow control block size and separation time.
module isotp_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isotp_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output isotp_pkg::fc_cfg_t                fc_cfg
);

    logic [7:0] stmin_reg;
    logic [7:0] bs_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stmin_reg <= isotp_pkg::ST_RESET;
            bs_reg    <= isotp_pkg::BS_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == isotp_pkg::REG_STMIN)
            begin
                stmin_reg <= pwdata[7:0];
            end
            else
            begin
                bs_reg <= pwdata[7:0];
            end
        end
    end

    // Read back.
    always_comb
    begin
        if (reg_sel == isotp_pkg::REG_BS)
        begin
            prdata = {24'd0, bs_reg};
        end
        else
        begin
            prdata = {24'd0, stmin_reg};
        end
    end

    assign fc_cfg.block_size      = bs_reg;
    assign fc_cfg.separation_time = stmin_reg;

endmodule

// ----- src/isotp_rx_core.sv -----
`timescale 1ns / 1ps
// Input register, reception state and single-pass frame decode.
module isotp_rx_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           frame_data,
    input  isotp_pkg::fc_cfg_t    fc_cfg,
    input  logic                  res_ready,
    output logic                  res_valid,
    output isotp_pkg::result_t    res
);

    logic [63:0] frame_reg;
    logic        frame_valid_reg;

    logic        receiving_reg;
    logic        receiving_next;
    logic [11:0] total_length_reg;
    logic [11:0] total_length_next;
    logic [11:0] received_offset_reg;
    logic [11:0] received_offset_next;
    logic [3:0]  expected_sequence_reg;
    logic [3:0]  expected_sequence_next;

    logic        in_accept;
    logic        step;
    logic [3:0]  kind;
    logic [3:0]  low;
    logic [55:0] body;
    logic [11:0] ff_len;
    logic [11:0] remain;
    logic [2:0]  chunk;
    logic [11:0] new_offset;

    // Top n bytes of a 56-bit field, the rest cleared.
    function automatic logic [55:0] keep_top(input logic [55:0] v, input logic [2:0] n);
        logic [55:0] mask;
        begin
            mask = ~({56{1'b1}} >> {n, 3'b000});
            keep_top = v & mask;
        end
    endfunction

    // Input stage holds one beat until the result stage can take it.
    assign in_stall  = frame_valid_reg && !res_ready;
    assign in_accept = in_valid && !in_stall;
    assign step      = frame_valid_reg && res_ready;
    assign res_valid = frame_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= in_stall || in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            frame_reg <= frame_data;
        end
    end

    // Field extraction.
    assign kind   = frame_reg[63:60];
    assign low    = frame_reg[59:56];
    assign body   = frame_reg[55:0];
    assign ff_len = {low, frame_reg[55:48]};
    assign remain = (total_length_reg > received_offset_reg)
                    ? (total_length_reg - received_offset_reg) : 12'd0;
    assign chunk  = (remain >= isotp_pkg::CF_MAX_CNT) ? isotp_pkg::CF_MAX_CNT[2:0]
                                                      : remain[2:0];
    assign new_offset = received_offset_reg + {9'd0, chunk};

    // Frame classification, result build and next state.
    always_comb
    begin
        res                    = '0;
        res.event_kind         = isotp_pkg::EV_IGNORED;
        receiving_next         = receiving_reg;
        total_length_next      = total_length_reg;
        received_offset_next   = received_offset_reg;
        expected_sequence_next = expected_sequence_reg;

        unique case (kind)
            isotp_pkg::FT_SINGLE:
            begin
                if (low <= isotp_pkg::SF_MAX_LEN)
                begin
                    res.event_kind         = isotp_pkg::EV_SINGLE_DONE;
                    res.payload_bytes      = keep_top(body, low[2:0]);
                    res.payload_count      = low[2:0];
                    res.message_length     = {8'd0, low};
                    receiving_next         = 1'b0;
                    received_offset_next   = '0;
                    expected_sequence_next = '0;
                end
            end
            isotp_pkg::FT_FIRST:
            begin
                if (ff_len >= isotp_pkg::FF_MIN_LEN)
                begin
                    res.event_kind         = isotp_pkg::EV_FIRST_OK;
                    res.payload_bytes      = {frame_reg[47:0], 8'd0};
                    res.payload_count      = isotp_pkg::FF_PAYLOAD_CNT;
                    res.message_length     = ff_len;
                    res.send_flow_control  = 1'b1;
                    res.fc_frame_bytes     = {isotp_pkg::FC_CTS_BYTE, fc_cfg.block_size,
                                              fc_cfg.separation_time};
                    receiving_next         = 1'b1;
                    total_length_next      = ff_len;
                    received_offset_next   = isotp_pkg::FF_NEXT_OFFSET;
                    expected_sequence_next = isotp_pkg::CF_FIRST_SEQ;
                end
            end
            isotp_pkg::FT_CONSECUTIVE:
            begin
                if (receiving_reg)
                begin
                    res.write_offset   = received_offset_reg;
                    res.message_length = total_length_reg;
                    if (low == expected_sequence_reg)
                    begin
                        res.payload_bytes = keep_top(body, chunk);
                        res.payload_count = chunk;
                        if (new_offset >= total_length_reg)
                        begin
                            res.event_kind         = isotp_pkg::EV_MSG_DONE;
                            receiving_next         = 1'b0;
                            received_offset_next   = '0;
                            expected_sequence_next = '0;
                        end
                        else
                        begin
                            res.event_kind         = isotp_pkg::EV_CONSEC_OK;
                            received_offset_next   = new_offset;
                            expected_sequence_next = expected_sequence_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        res.event_kind         = isotp_pkg::EV_SEQ_ERROR;
                        receiving_next         = 1'b0;
                        received_offset_next   = '0;
                        expected_sequence_next = '0;
                    end
                end
            end
            isotp_pkg::FT_FLOW:
            begin
                res.event_kind  = isotp_pkg::EV_FLOW;
                res.flow_status = low;
            end
            default:
            begin
                res.event_kind = isotp_pkg::EV_IGNORED;
            end
        endcase
    end

    // Reception state advances as each beat moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg         <= 1'b0;
            total_length_reg      <= '0;
            received_offset_reg   <= '0;
            expected_sequence_reg <= '0;
        end
        else if (step)
        begin
            receiving_reg         <= receiving_next;
            total_length_reg      <= total_length_next;
            received_offset_reg   <= received_offset_next;
            expected_sequence_reg <= expected_sequence_next;
        end
    end

endmodule

// ----- src/isotp_out_reg.sv -----
`timescale 1ns / 1ps
// Result register that holds one beat until the downstream side takes it.
module isotp_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  isotp_pkg::result_t  res,
    output logic                res_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output isotp_pkg::result_t  out_res
);

    logic               valid_reg;
    isotp_pkg::result_t res_reg;

    // The register can load when it is empty or being drained this cycle.
    assign res_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- src/isotp_frame_reassembler.sv -----
`timescale 1ns / 1ps
// Top level of the CAN transport protocol receive-side frame reassembler.
// An accepted frame is held in the input register, goes through one pass of decode logic
// and is then loaded into the result register, which presents its result beat.
// Throughput: one frame per cycle while the output is not stalled.
// Reset (rst_n, asynchronous, active low) empties both stages, returns the reception
// state to idle and loads separation time 5 and block size 0.
module isotp_frame_reassembler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [isotp_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [63:0]                       frame_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        event_kind,
    output logic [55:0]                       payload_bytes,
    output logic [2:0]                        payload_count,
    output logic [11:0]                       write_offset,
    output logic [11:0]                       message_length,
    output logic                              send_flow_control,
    output logic [23:0]                       fc_frame_bytes,
    output logic [3:0]                        flow_status
);

    isotp_pkg::fc_cfg_t   fc_cfg;
    isotp_pkg::result_t   res;
    isotp_pkg::result_t   out_res;
    logic                 res_valid;
    logic                 res_ready;

    isotp_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fc_cfg  (fc_cfg)
    );

    isotp_rx_core u_rx_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_data (frame_data),
        .fc_cfg     (fc_cfg),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    isotp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // Result fields onto their ports.
    assign event_kind        = out_res.event_kind;
    assign payload_bytes     = out_res.payload_bytes;
    assign payload_count     = out_res.payload_count;
    assign write_offset      = out_res.write_offset;
    assign message_length    = out_res.message_length;
    assign send_flow_control = out_res.send_flow_control;
    assign fc_frame_bytes    = out_res.fc_frame_bytes;
    assign flow_status       = out_res.flow_status;

endmodule
